[src/ttce_pkg.sv]
// Shared types and constants for the text terminal cursor engine.
// Used by ttce_step and text_terminal_cursor_engine_core; no dependencies.
package ttce_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = 11;

    // Cursor window bounds
    localparam logic [COL_W-1:0] COL_FIRST = COL_W'(2);
    localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(2);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_WIDTH - 3);
    localparam logic [COL_W:0]   COL_END   = (COL_W+1)'(SCREEN_WIDTH - 2);
    localparam logic [ROW_W:0]   ROW_END   = (ROW_W+1)'(SCREEN_HEIGHT - 2);
    localparam logic [COL_W:0]   TAB_STEP  = (COL_W+1)'(4);

    // Attributes
    localparam logic [7:0] COLOR_RESET = 8'h07;
    localparam logic [7:0] BELL_COLOR  = 8'h04;

    // Control characters
    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic ACT_PUT_CHAR  = 1'b0;
    localparam logic ACT_SET_COLOR = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
        logic [7:0] new_color;
    } in_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] cell_address;
        logic [15:0]       cell_word;
        logic              clear_screen;
        logic [7:0]        clear_body_color;
    } out_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [7:0]       color;
    } cursor_t;

endpackage

[src/text_terminal_cursor_engine_core.sv]
// Text terminal cursor engine: top level with input and result registers.
// Depends on ttce_pkg and ttce_step.
//
// Accepts one request per clock and returns exactly one result per request,
// registered first in the input register, then in the result register. A
// request loads the current attribute, applies a control character or puts
// a character into the framed window; the cursor and attribute update in the
// same cycle the result is registered, so back-to-back requests see each
// other's effect. Throughput is one request per cycle while m_ready stays
// high; the result register frees the input side whenever the result is taken.
module text_terminal_cursor_engine_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  ttce_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ttce_pkg::out_t  m_data
);
    import ttce_pkg::*;

    logic       in_valid_reg;
    in_t        in_data_reg;
    logic       out_valid_reg;
    out_t       out_data_reg;
    cursor_t    cur_reg;
    cursor_t    cur_next;
    out_t       res_next;
    logic [7:0] default_color_reg;
    logic       out_free;
    logic       fire;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    ttce_step u_step (
        .cur           (cur_reg),
        .req           (in_data_reg),
        .default_color (default_color_reg),
        .cur_next      (cur_next),
        .res           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            default_color_reg <= COLOR_RESET;
            cur_reg.column    <= COL_FIRST;
            cur_reg.row       <= ROW_FIRST;
            cur_reg.color     <= COLOR_RESET;
        end else begin
            if (cfg_wr_en) begin
                default_color_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            // Advance state and the result register together
            if (fire) begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= res_next;
        end
    end

endmodule

[src/ttce_step.sv]
// Next cursor state and result for one request of the cursor engine.
// Pure combinational; depends on ttce_pkg.
module ttce_step (
    input  ttce_pkg::cursor_t cur,
    input  ttce_pkg::in_t     req,
    input  logic [7:0]        default_color,
    output ttce_pkg::cursor_t cur_next,
    output ttce_pkg::out_t    res
);
    import ttce_pkg::*;

    logic [COL_W-1:0]  col_pre;
    logic [ROW_W-1:0]  row_pre;
    logic              do_advance;
    logic              do_write;
    logic [7:0]        write_char;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    tab_sum;
    logic [ROW_W:0]    vt_row;
    logic [ADDR_W+3:0] addr_full;

    always_comb begin
        col_pre    = cur.column;
        row_pre    = cur.row;
        do_advance = 1'b1;
        do_write   = 1'b0;
        write_char = req.char_code;
        cur_next   = cur;
        res        = '0;
        tab_sum    = {1'b0, cur.column} + TAB_STEP;
        vt_row     = {1'b0, cur.row} + (ROW_W+1)'(1);

        if (req.action == ACT_SET_COLOR) begin
            cur_next.color = req.new_color;
            do_advance     = 1'b0;
        end else begin
            case (req.char_code)
                CH_BS: begin
                    if (cur.column > COL_FIRST) begin
                        col_pre = cur.column - COL_W'(1);
                    end
                    do_write   = 1'b1;
                    write_char = CH_SPACE;
                end
                CH_LF: begin
                    col_pre = COL_LAST;
                end
                CH_TAB: begin
                    col_pre = (tab_sum >= {1'b0, COL_LAST}) ? COL_LAST : tab_sum[COL_W-1:0];
                end
                CH_CR: begin
                    col_pre = COL_FIRST;
                end
                CH_FF: begin
                    res.clear_screen     = 1'b1;
                    res.clear_body_color = cur.color;
                    col_pre              = COL_FIRST;
                    row_pre              = ROW_FIRST;
                end
                CH_VT: begin
                    row_pre = (vt_row >= ROW_END) ? ROW_FIRST : vt_row[ROW_W-1:0];
                end
                CH_BELL: begin
                    do_advance     = 1'b0;
                    cur_next.color = (cur.color != BELL_COLOR) ? BELL_COLOR : default_color;
                end
                default: begin
                    do_write = 1'b1;
                end
            endcase
        end

        // Write lands at the cursor before the advance
        addr_full = (ADDR_W+4)'(row_pre) * (ADDR_W+4)'(SCREEN_WIDTH)
                  + (ADDR_W+4)'(col_pre);
        if (do_write) begin
            res.write_valid  = 1'b1;
            res.cell_address = addr_full[ADDR_W-1:0];
            res.cell_word    = {cur.color, write_char};
        end

        // Advance: wrap column to next row, row back to the top
        col_inc = {1'b0, col_pre} + (COL_W+1)'(1);
        row_inc = {1'b0, row_pre} + (ROW_W+1)'(1);
        if (do_advance) begin
            if (col_inc >= COL_END) begin
                cur_next.column = COL_FIRST;
                cur_next.row    = (row_inc >= ROW_END) ? ROW_FIRST : row_inc[ROW_W-1:0];
            end else begin
                cur_next.column = col_inc[COL_W-1:0];
                cur_next.row    = row_pre;
            end
        end
    end

endmodule

[sim/ttce_cell_checker.sv]
// Result checker for the text terminal cursor engine: predicts each request's cell result.
// Watches both channels and the config port; depends on ttce_pkg.
`timescale 1ns / 1ps

module ttce_cell_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            s_valid,
    input  logic            s_ready,
    input  ttce_pkg::in_t   s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  ttce_pkg::out_t  m_data,
    output int              fail_count,
    output int              writes_seen,
    output int              clears_seen,
    output int              outstanding
);
    import ttce_pkg::*;

    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [7:0]       cur_color;
    logic [7:0]       dflt_color;

    out_t cells_due [$];

    function automatic void step_cursor();
        int col;
        int row;
        col = int'(cur_col) + 1;
        if (col >= SCREEN_WIDTH - 2) begin
            col = int'(COL_FIRST);
            row = int'(cur_row) + 1;
            if (row >= SCREEN_HEIGHT - 2) begin
                row = int'(ROW_FIRST);
            end
            cur_row = ROW_W'(row);
        end
        cur_col = COL_W'(col);
    endfunction

    function automatic out_t cell_write(input logic [7:0] ch);
        out_t res;
        int   addr;
        res = '0;
        addr = int'(cur_row) * SCREEN_WIDTH + int'(cur_col);
        res.write_valid  = 1'b1;
        res.cell_address = ADDR_W'(addr);
        res.cell_word    = {cur_color, ch};
        return res;
    endfunction

    function automatic out_t predict_cell(input in_t req);
        out_t res;
        int   col;
        int   row;
        res = '0;
        if (req.action == ACT_SET_COLOR) begin
            cur_color = req.new_color;
            return res;
        end
        case (req.char_code)
            CH_BS: begin
                if (cur_col > COL_FIRST) begin
                    cur_col = cur_col - COL_W'(1);
                end
                res = cell_write(CH_SPACE);
                step_cursor();
            end
            CH_LF: begin
                cur_col = COL_LAST;
                step_cursor();
            end
            CH_TAB: begin
                col = int'(cur_col) + 4;
                if (col >= SCREEN_WIDTH - 3) begin
                    col = SCREEN_WIDTH - 3;
                end
                cur_col = COL_W'(col);
                step_cursor();
            end
            CH_CR: begin
                cur_col = COL_FIRST;
                step_cursor();
            end
            CH_FF: begin
                res.clear_screen     = 1'b1;
                res.clear_body_color = cur_color;
                cur_row = ROW_FIRST;
                cur_col = COL_FIRST;
                step_cursor();
            end
            CH_VT: begin
                row = int'(cur_row) + 1;
                if (row >= SCREEN_HEIGHT - 2) begin
                    row = int'(ROW_FIRST);
                end
                cur_row = ROW_W'(row);
                step_cursor();
            end
            CH_BELL: begin
                cur_color = (cur_color != BELL_COLOR) ? BELL_COLOR : dflt_color;
            end
            default: begin
                res = cell_write(req.char_code);
                step_cursor();
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            cur_col     = COL_FIRST;
            cur_row     = ROW_FIRST;
            cur_color   = COLOR_RESET;
            dflt_color  = COLOR_RESET;
            fail_count  = 0;
            writes_seen = 0;
            clears_seen = 0;
            cells_due.delete();
        end else begin
            if (cfg_wr_en) begin
                dflt_color = cfg_wr_data;
            end
            // Check the result before queuing this edge's request.
            if (m_valid && m_ready) begin
                if (cells_due.size() == 0) begin
                    $error("result with no request outstanding: %h", m_data);
                    fail_count++;
                end else begin
                    want = cells_due.pop_front();
                    if (m_data.write_valid !== want.write_valid) begin
                        $error("write_valid: expected %0d, got %0d",
                               want.write_valid, m_data.write_valid);
                        fail_count++;
                    end
                    if (m_data.cell_address !== want.cell_address) begin
                        $error("cell_address: expected %0d, got %0d",
                               want.cell_address, m_data.cell_address);
                        fail_count++;
                    end
                    if (m_data.cell_word !== want.cell_word) begin
                        $error("cell_word: expected %h, got %h",
                               want.cell_word, m_data.cell_word);
                        fail_count++;
                    end
                    if (m_data.clear_screen !== want.clear_screen) begin
                        $error("clear_screen: expected %0d, got %0d",
                               want.clear_screen, m_data.clear_screen);
                        fail_count++;
                    end
                    if (m_data.clear_body_color !== want.clear_body_color) begin
                        $error("clear_body_color: expected %h, got %h",
                               want.clear_body_color, m_data.clear_body_color);
                        fail_count++;
                    end
                    if (want.write_valid) writes_seen++;
                    if (want.clear_screen) clears_seen++;
                end
            end
            if (s_valid && s_ready) begin
                cells_due.push_back(predict_cell(s_data));
            end
        end
        outstanding <= cells_due.size();
    end

endmodule

[sim/tb_text_terminal_cursor_engine_core.sv]
// Testbench top for text_terminal_cursor_engine_core: clock, reset, requests and verdict.
// Depends on ttce_pkg, the core and ttce_cell_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_text_terminal_cursor_engine_core;
    import ttce_pkg::*;

    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 200;
    localparam int CALM_ITEMS  = 120;

    localparam logic [7:0] CTRL_CHARS [7] = '{CH_BELL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_t        s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_t       m_data;

    int fail_count;
    int writes_seen;
    int clears_seen;
    int outstanding;

    int requests_sent = 0;
    bit calm          = 1'b0;
    bit gaps_on       = 1'b1;

    always #5 aclk = ~aclk;

    text_terminal_cursor_engine_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    ttce_cell_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .writes_seen (writes_seen),
        .clears_seen (clears_seen),
        .outstanding (outstanding)
    );

    function automatic in_t put_char(input logic [7:0] ch);
        in_t req;
        req.action    = ACT_PUT_CHAR;
        req.char_code = ch;
        req.new_color = 8'($urandom_range(0, 255));
        return req;
    endfunction

    function automatic in_t set_color(input logic [7:0] color);
        in_t req;
        req.action    = ACT_SET_COLOR;
        req.char_code = 8'($urandom_range(0, 255));
        req.new_color = color;
        return req;
    endfunction

    task automatic send_request(input in_t req);
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    // Hold off the sender until every result is back, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_default_color(input logic [7:0] color);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_burst();
        int kind;
        int n;
        kind    = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 3) != 0);
        if (kind < 35) begin
            // text run, long enough to wrap rows now and then
            n = $urandom_range(1, 90);
            repeat (n) send_request(put_char(8'($urandom_range(0, 255))));
        end else if (kind < 50) begin
            n = $urandom_range(1, 25);
            repeat (n) send_request(put_char($urandom_range(0, 1) ? CH_LF : CH_VT));
        end else if (kind < 70) begin
            send_request(put_char(CTRL_CHARS[$urandom_range(0, 6)]));
        end else if (kind < 80) begin
            n = $urandom_range(1, 20);
            repeat (n) send_request(put_char(CH_TAB));
        end else if (kind < 88) begin
            n = $urandom_range(2, 3);
            repeat (n) send_request(put_char(CH_BELL));
        end else if (kind < 95) begin
            send_request(set_color($urandom_range(0, 2) == 0 ? BELL_COLOR
                                                              : 8'($urandom_range(0, 255))));
        end else begin
            send_request(in_t'(17'($urandom)));
        end
    endtask

    initial begin : result_sink
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 30))
                    @(posedge aclk);
                if (!calm) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] color_plan [PHASES];
        int         goal;
        int         last_goal;
        int         p;
        color_plan[0] = 8'h00;
        color_plan[1] = 8'hFF;
        color_plan[2] = BELL_COLOR;
        color_plan[3] = 8'($urandom_range(0, 255));
        color_plan[4] = 8'($urandom_range(0, 255));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes and each control character, reset default color.
        send_request(put_char(8'h41));
        send_request(put_char(8'h00));
        send_request(put_char(8'hFF));
        send_request(put_char(CH_SPACE));
        send_request(put_char(CH_BS));
        send_request(put_char(CH_CR));
        send_request(put_char(CH_BS));
        send_request(put_char(CH_LF));
        send_request(put_char(CH_BS));
        send_request(put_char(CH_TAB));
        send_request(put_char(CH_TAB));
        send_request(put_char(CH_VT));
        send_request(put_char(CH_BELL));
        send_request(put_char(CH_BELL));
        send_request(in_t'{ACT_SET_COLOR, 8'hFF, BELL_COLOR});
        send_request(put_char(CH_BELL));
        send_request(in_t'{ACT_SET_COLOR, 8'h00, 8'hFF});
        send_request(put_char(8'h7F));
        send_request(set_color(8'h00));
        send_request(put_char(8'h80));
        send_request(put_char(CH_FF));
        send_request(put_char(8'h5A));
        send_request(put_char(CH_LF));

        last_goal = requests_sent + PHASES * PHASE_ITEMS;
        for (p = 0; p < PHASES; p++) begin
            write_default_color(color_plan[p]);
            goal = requests_sent + PHASE_ITEMS;
            while (requests_sent < goal) begin
                if (requests_sent >= last_goal - CALM_ITEMS) calm = 1'b1;
                send_burst();
            end
        end

        calm = 1'b1;
        drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d requests under %0d default color settings plus reset value;",
                 requests_sent, PHASES);
        $display("checked %0d cell writes and %0d clear requests.", writes_seen, clears_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("text_terminal_cursor_engine_core test passed");
        end else begin
            $display("text_terminal_cursor_engine_core test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("text_terminal_cursor_engine_core test failed");
        $finish;
    end

endmodule
